@@ rtl/winner_tree_kway_merge_coalesce_defines.svh @@
// Assertion macros for the winner tree merge block.
// Included by modules that carry concurrent assertions; expects clk and rst_n in scope.
`ifndef WINNER_TREE_KWAY_MERGE_COALESCE_DEFINES_SVH
`define WINNER_TREE_KWAY_MERGE_COALESCE_DEFINES_SVH

// Checks an implication on every rising clock edge, with checking held off during reset.
`define WTKM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a plain condition on every rising clock edge, with checking held off during reset.
`define WTKM_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

@@ rtl/wtkm_pkg.sv @@
// Shared types and constants for the winner tree merge block.
// No dependencies; imported by winner_tree_kway_merge_coalesce and tb_top.
package wtkm_pkg;

  localparam int WTKM_MAX_RUNS  = 16;
  localparam int WTKM_KEY_BYTES = 8;
  localparam int KEY_W          = 64;
  localparam int COUNT_W        = 31;
  localparam int RUNIDX_W       = 4;
  localparam int CFG_W          = 5;
  localparam int RUN_SPAN       = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_RECORD  = 1'b1;
  localparam logic ACT_LOAD     = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_COMB,
    ST_ADV
  } state_t;

  typedef struct packed {
    logic                kind;
    logic [RUNIDX_W-1:0] run;
    logic [KEY_W-1:0]    key;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } result_t;

endpackage

@@ rtl/winner_tree_kway_merge_coalesce.sv @@
// K-way merge of sorted runs through a winner tree held in a node memory, with coalescing.
// Depends on wtkm_pkg and winner_tree_kway_merge_coalesce_defines.svh.
//
// The block merges up to runs_in_use sorted runs. In the fill phase each run in use sends
// its first record or an exhaustion mark; after the last one arrives the whole winner
// tree is built bottom-up, one internal node at a time (a read of both children from the
// node memory, then a compare and write-back) for all LEAVES-1 internal nodes, where LEAVES
// is MAX_RUNS rounded up to a power of two. In the merge phase only a record (or
// exhaustion) for the run that the block last requested is taken; it replays one
// leaf-to-root path with the same steps, then a coalesce step on the new root. Items for
// other runs are dropped. Each item gives at most two results (a finished merged record
// and a request for the next record); they wait in a two-entry output buffer and the
// next input is taken once both have been transferred. When every run is exhausted the
// held record goes out with last set and the block returns to the fill phase. Equal keys
// add their counts, saturating at 2^31-1.
module winner_tree_kway_merge_coalesce #(
  parameter int MAX_RUNS  = wtkm_pkg::WTKM_MAX_RUNS,
  parameter int KEY_BYTES = wtkm_pkg::WTKM_KEY_BYTES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_action,
  input  logic [wtkm_pkg::RUNIDX_W-1:0]    in_run_index,
  input  logic [wtkm_pkg::KEY_W-1:0]       in_record_key,
  input  logic [wtkm_pkg::COUNT_W-1:0]     in_record_count,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_kind,
  output logic [wtkm_pkg::RUNIDX_W-1:0]    out_request_run,
  output logic [wtkm_pkg::KEY_W-1:0]       out_merged_key,
  output logic [wtkm_pkg::COUNT_W-1:0]     out_merged_count,
  output logic                             out_last
);
  import wtkm_pkg::*;
  `include "winner_tree_kway_merge_coalesce_defines.svh"

  localparam int LEAVES  = 1 << $clog2(MAX_RUNS);
  localparam int RUN_W   = $clog2(LEAVES);
  localparam int NODES   = 2 * LEAVES - 1;
  localparam int NODE_W  = $clog2(NODES);
  localparam int RUN_CAP = (MAX_RUNS < RUN_SPAN) ? MAX_RUNS : RUN_SPAN;
  localparam logic [NODE_W-1:0] LEAF_BASE  = NODE_W'(LEAVES - 1);
  localparam logic [NODE_W-1:0] BUILD_TOP  = NODE_W'(LEAVES - 2);
  localparam logic [KEY_W-1:0]  KEY_MASK   = {KEY_W{1'b1}} << (8 * (8 - KEY_BYTES));

  // One tree entry: for a leaf it is the run's current record, for an internal node a
  // copy of the winning leaf. Leaf validity lives in leaf_v_r instead of the entry.
  typedef struct packed {
    logic             valid;
    logic [RUN_W-1:0] run;
    logic [KEY_W-1:0] key;
    logic [COUNT_W-1:0] count;
  } node_t;

  node_t node_mem [NODES];
  node_t rd_a_r, rd_b_r;
  logic              mem_we;
  logic [NODE_W-1:0] mem_waddr;
  node_t             mem_wdata;
  logic              mem_re;
  logic [NODE_W-1:0] rd_addr_a, rd_addr_b;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]   runs_r;
  logic [LEAVES-1:0]  leaf_v_r, loaded_r;
  logic               merging_r, build_r;
  logic [NODE_W-1:0]  node_r;
  node_t              root_r;
  logic [KEY_W-1:0]   held_key_r;
  logic [COUNT_W-1:0] held_count_r;
  logic               held_valid_r;
  result_t            res_q_r [2];
  logic [1:0]         q_cnt_r;

  // Configuration port: single register, zero wait states.
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {27'd0, runs_r} : 32'd0;

  // Runs in use, clamped to the legal range.
  logic [CFG_W-1:0]  used;
  logic [LEAVES-1:0] need;
  always_comb begin
    if (runs_r == '0) begin
      used = CFG_W'(1);
    end else if (runs_r > CFG_W'(RUN_CAP)) begin
      used = CFG_W'(RUN_CAP);
    end else begin
      used = runs_r;
    end
    for (int i = 0; i < LEAVES; i++) begin
      need[i] = (i < int'(used));
    end
  end

  // Input decode.
  logic               fire;
  logic [RUN_W-1:0]   leaf_idx;
  logic [KEY_W-1:0]   key_in;
  logic               fill_take, fill_done, walk_hit;
  logic [LEAVES-1:0]  loaded_new;
  logic [LEAVES-1:0]  leaf_v_fill;
  logic [NODE_W-1:0]  leaf_node;
  assign fire      = in_valid && in_ready;
  assign leaf_idx  = RUN_W'(in_run_index);
  assign key_in    = in_record_key & KEY_MASK;
  assign leaf_node = LEAF_BASE + NODE_W'(leaf_idx);
  always_comb begin
    fill_take   = ({1'b0, in_run_index} < used) && !loaded_r[leaf_idx];
    loaded_new  = loaded_r;
    leaf_v_fill = leaf_v_r;
    if (fill_take) begin
      loaded_new[leaf_idx]  = 1'b1;
      leaf_v_fill[leaf_idx] = (in_action == ACT_LOAD);
    end
    fill_done = &(loaded_new | ~need);
    walk_hit  = root_r.valid && (32'(in_run_index) < MAX_RUNS) && (root_r.run == leaf_idx);
  end

  // Combine of the two children of node_r, from the registered read data.
  logic [NODE_W-1:0] child_a, child_b;
  logic              va, vb;
  node_t             comb_node;
  assign child_a = NODE_W'(2 * node_r + 1);
  assign child_b = NODE_W'(2 * node_r + 2);
  always_comb begin
    va = (child_a >= LEAF_BASE) ? leaf_v_r[RUN_W'(child_a - LEAF_BASE)] : rd_a_r.valid;
    vb = (child_b >= LEAF_BASE) ? leaf_v_r[RUN_W'(child_b - LEAF_BASE)] : rd_b_r.valid;
    if (va && (!vb || rd_a_r.key <= rd_b_r.key)) begin
      comb_node = rd_a_r;
      comb_node.valid = 1'b1;
    end else if (vb) begin
      comb_node = rd_b_r;
      comb_node.valid = 1'b1;
    end else begin
      comb_node = '0;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (fire) begin
          if (!merging_r) begin
            state_nxt = fill_done ? ST_READ : ST_IDLE;
          end else begin
            state_nxt = walk_hit ? ST_READ : ST_IDLE;
          end
        end
      end
      ST_READ: state_nxt = ST_COMB;
      ST_COMB: state_nxt = (node_r == '0) ? ST_ADV : ST_READ;
      ST_ADV:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready  = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = leaf_node;
    mem_wdata = '{valid: 1'b1, run: leaf_idx, key: key_in, count: in_record_count};
    unique case (state_r)
      ST_IDLE: begin
        in_ready = (q_cnt_r == 2'd0);
        mem_we   = fire && (in_action == ACT_LOAD) && (merging_r ? walk_hit : fill_take);
      end
      ST_READ: mem_re = 1'b1;
      ST_COMB: begin
        mem_we    = 1'b1;
        mem_waddr = node_r;
        mem_wdata = comb_node;
      end
      ST_ADV: ;
      default: ;
    endcase
  end

  assign rd_addr_a = child_a;
  assign rd_addr_b = child_b;

  // Node memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_a_r <= node_mem[rd_addr_a];
      rd_b_r <= node_mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Coalesce step on the current root.
  logic [COUNT_W:0] sum;
  assign sum = {1'b0, held_count_r} + {1'b0, root_r.count};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      runs_r       <= CFG_W'(RUN_SPAN);
      leaf_v_r     <= '0;
      loaded_r     <= '0;
      merging_r    <= 1'b0;
      build_r      <= 1'b0;
      node_r       <= '0;
      root_r       <= '0;
      held_key_r   <= '0;
      held_count_r <= '0;
      held_valid_r <= 1'b0;
      q_cnt_r      <= 2'd0;
    end else begin
      if (cfg_wr) begin
        runs_r <= pwdata[CFG_W-1:0];
      end
      if (out_valid && out_ready) begin
        res_q_r[0] <= res_q_r[1];
        q_cnt_r    <= q_cnt_r - 2'd1;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (fire && !merging_r) begin
            // Runs that are no longer in use when the fill completes stay out of the tree.
            leaf_v_r <= fill_done ? (leaf_v_fill & need) : leaf_v_fill;
            loaded_r <= loaded_new;
            if (fill_done) begin
              merging_r <= 1'b1;
              build_r   <= 1'b1;
              node_r    <= BUILD_TOP;
            end
          end else if (fire && walk_hit) begin
            leaf_v_r[leaf_idx] <= (in_action == ACT_LOAD);
            build_r <= 1'b0;
            node_r  <= (leaf_node - NODE_W'(1)) >> 1;
          end
        end
        ST_READ: ;
        ST_COMB: begin
          if (node_r == '0) begin
            root_r <= comb_node;
          end else if (build_r) begin
            node_r <= node_r - NODE_W'(1);
          end else begin
            node_r <= (node_r - NODE_W'(1)) >> 1;
          end
        end
        ST_ADV: begin
          if (!root_r.valid) begin
            // Every run is exhausted: flush the held record and start over.
            res_q_r[0] <= '{kind: KIND_RECORD, run: '0,
                            key: held_valid_r ? held_key_r : '0,
                            count: held_valid_r ? held_count_r : '0, last: 1'b1};
            q_cnt_r      <= 2'd1;
            merging_r    <= 1'b0;
            loaded_r     <= '0;
            leaf_v_r     <= '0;
            root_r       <= '0;
            held_key_r   <= '0;
            held_count_r <= '0;
            held_valid_r <= 1'b0;
          end else if (held_valid_r && held_key_r == root_r.key) begin
            held_count_r <= sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
            res_q_r[0] <= '{kind: KIND_REQUEST, run: RUNIDX_W'(root_r.run),
                            key: '0, count: '0, last: 1'b0};
            q_cnt_r <= 2'd1;
          end else begin
            held_key_r   <= root_r.key;
            held_count_r <= root_r.count;
            held_valid_r <= 1'b1;
            if (held_valid_r) begin
              res_q_r[0] <= '{kind: KIND_RECORD, run: '0, key: held_key_r,
                              count: held_count_r, last: 1'b0};
              res_q_r[1] <= '{kind: KIND_REQUEST, run: RUNIDX_W'(root_r.run),
                              key: '0, count: '0, last: 1'b0};
              q_cnt_r <= 2'd2;
            end else begin
              res_q_r[0] <= '{kind: KIND_REQUEST, run: RUNIDX_W'(root_r.run),
                              key: '0, count: '0, last: 1'b0};
              q_cnt_r <= 2'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid        = (q_cnt_r != 2'd0);
  assign out_kind         = res_q_r[0].kind;
  assign out_request_run  = res_q_r[0].run;
  assign out_merged_key   = res_q_r[0].key;
  assign out_merged_count = res_q_r[0].count;
  assign out_last         = res_q_r[0].last;

  // Every advance step leaves at least one result waiting.
  `WTKM_ASSERT(a_adv_gives_result, (state_r == ST_ADV) |=> (q_cnt_r != 2'd0), "advance without result")
  // The output buffer never holds more than two results.
  `WTKM_ASSERT_NOW(a_q_bound, q_cnt_r != 2'd3, "output buffer overflow")
  // Leaving the merge phase always comes with the final record.
  `WTKM_ASSERT(a_last_on_end, $fell(merging_r) |-> (out_valid && out_last), "merge ended without last")
  // Tree walks only run while no result is waiting.
  `WTKM_ASSERT(a_walk_q_empty, (state_r == ST_READ) |-> (q_cnt_r == 2'd0), "walk with results pending")
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for winner_tree_kway_merge_coalesce: random sorted runs are merged
// in closed loop, answering each request of the block, and results are checked in order.
// Depends on wtkm_pkg and the RTL top level only.
module tb_top;
  import wtkm_pkg::*;

  localparam int NO_XFER_LIMIT = 20000;
  localparam int DRAIN_CYCLES  = 80;

  typedef struct {
    logic                action;
    logic [RUNIDX_W-1:0] run;
    logic [KEY_W-1:0]    key;
    logic [COUNT_W-1:0]  count;
  } record_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_ready;
  logic in_action = 1'b0;
  logic [RUNIDX_W-1:0] in_run_index = '0;
  logic [KEY_W-1:0] in_record_key = '0;
  logic [COUNT_W-1:0] in_record_count = '0;
  logic out_valid, out_ready = 1'b0;
  logic out_kind, out_last;
  logic [RUNIDX_W-1:0] out_request_run;
  logic [KEY_W-1:0] out_merged_key;
  logic [COUNT_W-1:0] out_merged_count;

  always #1 clk = ~clk;

  winner_tree_kway_merge_coalesce u_top (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_run_index(in_run_index), .in_record_key(in_record_key),
    .in_record_count(in_record_count),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_request_run(out_request_run), .out_merged_key(out_merged_key),
    .out_merged_count(out_merged_count), .out_last(out_last)
  );

  // Items waiting to be driven, results still owed by the block, and the runs that the
  // block has asked for but that have not been answered yet.
  record_item_t pending_items[$];
  result_t      owed_results[$];
  int           asked_runs[$];
  int           merges_finished = 0;
  int           items_accepted = 0;
  int           mismatches = 0;
  int           send_idle = 23;
  int           recv_idle = 64;
  int           quiet_cycles = 0;

  // Shadow of the merge state. A leaf is live when it holds a record; the winner is the
  // smallest live key, and on equal keys the lower run, which is what the tree yields.
  logic [4:0]         shadow_runs_cfg = 5'd16;
  logic [KEY_W-1:0]   leaf_keys [RUN_SPAN];
  logic [COUNT_W-1:0] leaf_counts [RUN_SPAN];
  bit                 leaf_live [RUN_SPAN];
  bit                 leaf_filled [RUN_SPAN];
  logic [KEY_W-1:0]   held_key = '0;
  logic [COUNT_W-1:0] held_count = '0;
  bit                 held_valid = 1'b0;
  bit                 merging = 1'b0;

  function automatic int runs_used();
    if (shadow_runs_cfg == 0) return 1;
    if (shadow_runs_cfg > RUN_SPAN) return RUN_SPAN;
    return int'(shadow_runs_cfg);
  endfunction

  function automatic int tree_winner();
    int w;
    w = -1;
    for (int i = 0; i < RUN_SPAN; i++)
      if (leaf_live[i] && (w < 0 || leaf_keys[i] < leaf_keys[w])) w = i;
    return w;
  endfunction

  function automatic void clear_merge_state();
    for (int i = 0; i < RUN_SPAN; i++) begin
      leaf_live[i] = 1'b0;
      leaf_filled[i] = 1'b0;
    end
    held_key = '0;
    held_count = '0;
    held_valid = 1'b0;
    merging = 1'b0;
  endfunction

  function automatic void take_winner();
    int w;
    logic [31:0] sum;
    result_t r;
    w = tree_winner();
    if (w < 0) begin
      r = '{KIND_RECORD, '0, held_valid ? held_key : '0, held_valid ? held_count : '0, 1'b1};
      owed_results.push_back(r);
      clear_merge_state();
      return;
    end
    if (!held_valid) begin
      held_key = leaf_keys[w];
      held_count = leaf_counts[w];
      held_valid = 1'b1;
    end else if (held_key == leaf_keys[w]) begin
      sum = {1'b0, held_count} + {1'b0, leaf_counts[w]};
      held_count = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_W-1:0];
    end else begin
      r = '{KIND_RECORD, '0, held_key, held_count, 1'b0};
      owed_results.push_back(r);
      held_key = leaf_keys[w];
      held_count = leaf_counts[w];
    end
    r = '{KIND_REQUEST, RUNIDX_W'(w), '0, '0, 1'b0};
    owed_results.push_back(r);
  endfunction

  function automatic void merge_step(record_item_t it);
    int used;
    int r;
    r = int'(it.run);
    if (!merging) begin
      used = runs_used();
      if (r < used && !leaf_filled[r]) begin
        leaf_live[r] = (it.action == ACT_LOAD);
        leaf_keys[r] = it.key;
        leaf_counts[r] = it.count;
        leaf_filled[r] = 1'b1;
      end
      for (int i = 0; i < used; i++)
        if (!leaf_filled[i]) return;
      for (int i = used; i < RUN_SPAN; i++) leaf_live[i] = 1'b0;
      merging = 1'b1;
      take_winner();
    end else begin
      if (tree_winner() != r) return;
      leaf_live[r] = (it.action == ACT_LOAD);
      leaf_keys[r] = it.key;
      leaf_counts[r] = it.count;
      take_winner();
    end
  endfunction

  // Driver: the prediction is made on the accepted transfer before the next item goes out.
  always @(posedge clk) begin
    record_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        it = '{in_action, in_run_index, in_record_key, in_record_count};
        merge_step(it);
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
          it = pending_items.pop_front();
          in_action <= it.action;
          in_run_index <= it.run;
          in_record_key <= it.key;
          in_record_count <= it.count;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every result transfer against the oldest owed result and feeds the
  // requests back to the stimulus thread.
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind=%0d run=%0d key=%h count=%0d last=%0d",
                     out_kind, out_request_run, out_merged_key, out_merged_count, out_last);
        end else begin
          want = owed_results.pop_front();
          if (out_kind !== want.kind || out_request_run !== want.run ||
              out_merged_key !== want.key || out_merged_count !== want.count ||
              out_last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp kind=%0d run=%0d key=%h count=%0d last=%0d, got kind=%0d run=%0d key=%h count=%0d last=%0d",
                       want.kind, want.run, want.key, want.count, want.last,
                       out_kind, out_request_run, out_merged_key, out_merged_count,
                       out_last);
          end
          if (want.kind == KIND_REQUEST) asked_runs.push_back(int'(want.run));
          if (want.last) merges_finished++;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= NO_XFER_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || owed_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_runs_in_use(logic [4:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'd0;
    pwdata <= {27'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_runs_cfg = value;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return {$urandom, $urandom};
      default: return {56'h4d45524745, 8'($urandom_range(3))};
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count(bit near_max);
    if (near_max) return COUNT_MAX - COUNT_W'($urandom_range(2));
    if ($urandom_range(9) == 0) return COUNT_W'($urandom);
    return COUNT_W'($urandom_range(1, 20));
  endfunction

  function automatic record_item_t stray_item(int avoid_run);
    record_item_t it;
    it = '{1'($urandom), RUNIDX_W'($urandom), {$urandom, $urandom}, COUNT_W'($urandom)};
    if (int'(it.run) == avoid_run) it.run = it.run + 1'b1;
    return it;
  endfunction

  // One complete merge: builds sorted runs, loads them in random order, then answers each
  // request of the block until the final record comes back.
  task automatic merge_pass(logic [4:0] cfg_value, int max_len, bit near_max);
    logic [KEY_W-1:0]   run_keys [RUN_SPAN][$];
    logic [COUNT_W-1:0] run_counts [RUN_SPAN][$];
    int fill_order[$];
    int used;
    int target;
    int finished_at;
    record_item_t it;
    if (cfg_value != shadow_runs_cfg) begin
      wait_idle();
      write_runs_in_use(cfg_value);
    end
    used = runs_used();
    for (int r = 0; r < used; r++) begin
      repeat ($urandom_range(max_len)) begin
        run_keys[r].push_back(pick_key());
        run_counts[r].push_back(pick_count(near_max));
      end
      run_keys[r].sort();
      fill_order.push_back(r);
    end
    fill_order.shuffle();
    finished_at = merges_finished;
    foreach (fill_order[i]) begin
      // Strays in the fill phase hit runs that are out of use or already loaded.
      if (i > 0 && $urandom_range(6) == 0) begin
        it = stray_item(-1);
        if (int'(it.run) < used) it.run = RUNIDX_W'(fill_order[$urandom_range(i - 1)]);
        pending_items.push_back(it);
      end
      target = fill_order[i];
      if (run_keys[target].size() > 0)
        it = '{ACT_LOAD, RUNIDX_W'(target), run_keys[target].pop_front(),
               run_counts[target].pop_front()};
      else
        it = '{~ACT_LOAD, RUNIDX_W'(target), {$urandom, $urandom}, COUNT_W'($urandom)};
      pending_items.push_back(it);
    end
    forever begin
      while (asked_runs.size() == 0 && merges_finished == finished_at) @(posedge clk);
      if (merges_finished != finished_at) break;
      target = asked_runs.pop_front();
      if ($urandom_range(9) == 0) pending_items.push_back(stray_item(target));
      if (run_keys[target].size() > 0)
        it = '{ACT_LOAD, RUNIDX_W'(target), run_keys[target].pop_front(),
               run_counts[target].pop_front()};
      else
        it = '{~ACT_LOAD, RUNIDX_W'(target), {$urandom, $urandom}, COUNT_W'($urandom)};
      pending_items.push_back(it);
    end
  endtask

  initial begin
    clear_merge_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed merges: a single run that is empty from the start, a zero register that
    // acts as one run, counts that saturate on equal keys, an oversized register and all runs empty.
    merge_pass(5'd1, 0, 1'b0);
    merge_pass(5'd0, 3, 1'b0);
    merge_pass(5'd2, 3, 1'b1);
    merge_pass(5'd31, 1, 1'b0);
    merge_pass(5'd16, 0, 1'b0);

    while (items_accepted < 400) begin
      if (items_accepted > 260) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (items_accepted > 130) begin
        send_idle = 64;
        recv_idle = 23;
      end
      merge_pass(5'($urandom_range(17)), 4, ($urandom_range(7) == 0));
    end

    wait_idle();
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/wtkm_pkg.sv
rtl/winner_tree_kway_merge_coalesce.sv
tb/tb_top.sv
